[hw/rtl/dnsd_pkg.sv]
// Package: shared constants, types and codes of the DNS name decompressor.
`timescale 1ns / 1ps

package dnsd_pkg;

  localparam int STORE_BYTES_DEF      = 512;
  localparam int MAX_NAME_CHARS_DEF   = 255;
  localparam int CHARS_PER_RESULT_DEF = 8;

  localparam int POS_W     = 9;
  localparam int BYTE_W    = 8;
  localparam int PTR_W     = 15;
  localparam int OFF_HI_W  = 6;
  localparam int CHUNK_W   = 64;
  localparam int CNT_W     = 4;
  localparam int CONS_W    = 10;
  localparam int HOPS_W    = 5;
  localparam int HOP_CNT_W = 6;
  localparam int LEN_W     = 8;
  localparam int NEED_W    = 10;

  localparam logic [HOPS_W-1:0] HOPS_RESET = 5'd8;
  localparam logic [BYTE_W-1:0] PTR_MARK   = 8'd192;
  localparam logic [BYTE_W-1:0] DOT_CHAR   = 8'h2E;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_HOPS  = 2'd1,
    STAT_LONG  = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    W_IDLE,
    W_FETCH,
    W_BYTE,
    W_PTR,
    W_LABEL,
    W_DONE,
    W_WAIT
  } walk_state_e;

  typedef enum logic [1:0] {
    P_IDLE,
    P_GATHER,
    P_FIN
  } pack_state_e;

  typedef struct packed {
    logic              en;
    logic [LEN_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } name_wr_t;

  typedef struct packed {
    logic              start;
    logic [LEN_W-1:0]  len;
    logic [CONS_W-1:0] consumed;
    status_e           status;
  } job_t;

endpackage

[hw/rtl/dnsd_walker.sv]
// Walker: message store, load path and label/pointer walk sequencer.
`timescale 1ns / 1ps

module dnsd_walker
  import dnsd_pkg::*;
#(
  parameter int STORE_BYTES    = STORE_BYTES_DEF,
  parameter int MAX_NAME_CHARS = MAX_NAME_CHARS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              in_operation_i,
  input  logic [POS_W-1:0]  in_position_i,
  input  logic [BYTE_W-1:0] in_byte_value_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [HOPS_W-1:0] cfg_max_pointer_hops_i,
  output name_wr_t          name_wr_o,
  output job_t              job_o,
  input  logic              pack_done_i
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam logic [PTR_W-1:0]  STORE_LIM = PTR_W'(STORE_BYTES);
  localparam logic [NEED_W-1:0] NAME_LIM  = NEED_W'(MAX_NAME_CHARS);

  walk_state_e state_q, state_d;
  logic [PTR_W-1:0]     wp_q, wp_d;
  logic [POS_W-1:0]     start_q, start_d;
  logic [HOP_CNT_W-1:0] hop_q, hop_d;
  logic [LEN_W-1:0]     rem_q, rem_d;
  logic [LEN_W-1:0]     len_q, len_d;
  logic                 jumped_q, jumped_d;
  logic [CONS_W-1:0]    cons_q, cons_d;
  status_e              status_q, status_d;
  logic [OFF_HI_W-1:0]  hi_q, hi_d;
  logic                 pend_q, pend_d;
  logic [HOPS_W-1:0]    max_hops_q;

  logic [BYTE_W-1:0] mem [STORE_BYTES];
  logic [BYTE_W-1:0] rdata_q;
  logic [AW-1:0]     raddr;
  logic              st_we;
  logic [PTR_W-1:0]  pos_ext;
  logic              accept;
  logic [PTR_W-1:0]  span;
  logic [NEED_W-1:0] need;
  logic [PTR_W-1:0]  label_end;
  logic [PTR_W-1:0]  wp_next;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != W_IDLE);
  assign cfg_ready_o = 1'b1;
  assign pos_ext     = {{(PTR_W-POS_W){1'b0}}, in_position_i};
  assign st_we       = accept && (op_e'(in_operation_i) == OP_LOAD) && (pos_ext < STORE_LIM);
  assign span        = wp_q - {{(PTR_W-POS_W){1'b0}}, start_q};
  assign need        = {{(NEED_W-LEN_W){1'b0}}, len_q}
                     + ((len_q != '0) ? NEED_W'(1) : NEED_W'(0))
                     + {{(NEED_W-BYTE_W){1'b0}}, rdata_q};
  assign label_end   = wp_q + {{(PTR_W-BYTE_W){1'b0}}, rdata_q};
  assign wp_next     = wp_q + PTR_W'(1);

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      mem[pos_ext[AW-1:0]] <= in_byte_value_i;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_hops_q <= HOPS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_hops_q <= cfg_max_pointer_hops_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= W_IDLE;
      wp_q     <= '0;
      hop_q    <= '0;
      rem_q    <= '0;
      len_q    <= '0;
      jumped_q <= 1'b0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      wp_q     <= wp_d;
      hop_q    <= hop_d;
      rem_q    <= rem_d;
      len_q    <= len_d;
      jumped_q <= jumped_d;
      pend_q   <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q  <= start_d;
    cons_q   <= cons_d;
    status_q <= status_d;
    hi_q     <= hi_d;
  end

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    start_d   = start_q;
    hop_d     = hop_q;
    rem_d     = rem_q;
    len_d     = len_q;
    jumped_d  = jumped_q;
    cons_d    = cons_q;
    status_d  = status_q;
    hi_d      = hi_q;
    pend_d    = pend_q;
    raddr     = wp_q[AW-1:0];
    name_wr_o = '0;
    job_o     = '0;
    case (state_q)
      W_IDLE: begin
        if (accept && (op_e'(in_operation_i) == OP_DECODE)) begin
          wp_d     = pos_ext;
          start_d  = in_position_i;
          hop_d    = '0;
          rem_d    = '0;
          len_d    = '0;
          jumped_d = 1'b0;
          cons_d   = '0;
          status_d = STAT_OK;
          pend_d   = 1'b0;
          state_d  = W_FETCH;
        end
      end
      W_FETCH: begin
        if (wp_q >= STORE_LIM) begin
          status_d = STAT_RANGE;
          state_d  = W_DONE;
        end else begin
          state_d = W_BYTE;
        end
      end
      W_BYTE: begin
        if (rdata_q == '0) begin
          if (!jumped_q) begin
            cons_d = CONS_W'(span + PTR_W'(1));
          end
          state_d = W_DONE;
        end else if (rdata_q >= PTR_MARK) begin
          if (wp_next >= STORE_LIM) begin
            status_d = STAT_RANGE;
            state_d  = W_DONE;
          end else begin
            raddr   = wp_next[AW-1:0];
            hi_d    = rdata_q[OFF_HI_W-1:0];
            state_d = W_PTR;
          end
        end else if (need > NAME_LIM) begin
          status_d = STAT_LONG;
          state_d  = W_DONE;
        end else if (label_end >= STORE_LIM) begin
          status_d = STAT_RANGE;
          state_d  = W_DONE;
        end else begin
          if (len_q != '0) begin
            name_wr_o.en   = 1'b1;
            name_wr_o.addr = len_q;
            name_wr_o.data = DOT_CHAR;
            len_d          = len_q + LEN_W'(1);
          end
          rem_d   = rdata_q;
          wp_d    = wp_next;
          pend_d  = 1'b0;
          state_d = W_LABEL;
        end
      end
      W_PTR: begin
        if (!jumped_q) begin
          cons_d   = CONS_W'(span + PTR_W'(2));
          jumped_d = 1'b1;
        end
        hop_d = hop_q + HOP_CNT_W'(1);
        if (hop_d > {{(HOP_CNT_W-HOPS_W){1'b0}}, max_hops_q}) begin
          status_d = STAT_HOPS;
          state_d  = W_DONE;
        end else begin
          wp_d    = {{(PTR_W-OFF_HI_W-BYTE_W){1'b0}}, hi_q, rdata_q};
          state_d = W_FETCH;
        end
      end
      W_LABEL: begin
        if (pend_q) begin
          name_wr_o.en   = 1'b1;
          name_wr_o.addr = len_q;
          name_wr_o.data = rdata_q;
          len_d          = len_q + LEN_W'(1);
        end
        if (rem_q != '0) begin
          wp_d   = wp_next;
          rem_d  = rem_q - LEN_W'(1);
          pend_d = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = W_FETCH;
        end
      end
      W_DONE: begin
        job_o.start    = 1'b1;
        job_o.len      = len_q;
        job_o.consumed = cons_q;
        job_o.status   = status_q;
        state_d        = W_WAIT;
      end
      W_WAIT: begin
        if (pack_done_i) begin
          state_d = W_IDLE;
        end
      end
      default: begin
        state_d = W_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/dnsd_packer.sv]
// Packer: name buffer, chunk assembly and result output register.
`timescale 1ns / 1ps

module dnsd_packer
  import dnsd_pkg::*;
#(
  parameter int MAX_NAME_CHARS   = MAX_NAME_CHARS_DEF,
  parameter int CHARS_PER_RESULT = CHARS_PER_RESULT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  name_wr_t           name_wr_i,
  input  job_t               job_i,
  output logic               done_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CHUNK_W-1:0] out_name_chunk_o,
  output logic [CNT_W-1:0]   out_chunk_bytes_o,
  output logic               out_last_chunk_o,
  output logic [CONS_W-1:0]  out_consumed_bytes_o,
  output logic [1:0]         out_status_o
);

  localparam int NAW = $clog2(MAX_NAME_CHARS);
  localparam logic [CNT_W-1:0] CPR = CNT_W'(CHARS_PER_RESULT);

  pack_state_e state_q, state_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [CONS_W-1:0]  cons_q, cons_d;
  status_e            status_q, status_d;
  logic [LEN_W-1:0]   pos_q, pos_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               pend_q, pend_d;
  logic [CHUNK_W-1:0] chunk_q, chunk_d;

  logic               ov_q, ov_d;
  logic [CHUNK_W-1:0] oc_q, oc_d;
  logic [CNT_W-1:0]   ob_q, ob_d;
  logic               ol_q, ol_d;
  logic [CONS_W-1:0]  ocons_q, ocons_d;
  status_e            ost_q, ost_d;

  logic [BYTE_W-1:0] mem [MAX_NAME_CHARS];
  logic [BYTE_W-1:0] nrdata_q;
  logic [CNT_W-1:0]  cnt_n;
  logic              out_free;
  logic              issue;
  logic              last;

  assign out_free             = !ov_q || !out_stall_i;
  assign out_valid_o          = ov_q;
  assign out_name_chunk_o     = oc_q;
  assign out_chunk_bytes_o    = ob_q;
  assign out_last_chunk_o     = ol_q;
  assign out_consumed_bytes_o = ocons_q;
  assign out_status_o         = ost_q;

  always_ff @(posedge clk_i) begin
    if (name_wr_i.en) begin
      mem[name_wr_i.addr[NAW-1:0]] <= name_wr_i.data;
    end
    nrdata_q <= mem[pos_q[NAW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_IDLE;
      pos_q   <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q    <= len_d;
    cons_q   <= cons_d;
    status_q <= status_d;
    chunk_q  <= chunk_d;
    oc_q     <= oc_d;
    ob_q     <= ob_d;
    ol_q     <= ol_d;
    ocons_q  <= ocons_d;
    ost_q    <= ost_d;
  end

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    cons_d   = cons_q;
    status_d = status_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    pend_d   = pend_q;
    chunk_d  = chunk_q;
    ov_d     = ov_q && out_stall_i;
    oc_d     = oc_q;
    ob_d     = ob_q;
    ol_d     = ol_q;
    ocons_d  = ocons_q;
    ost_d    = ost_q;
    done_o   = 1'b0;
    cnt_n    = cnt_q;
    issue    = 1'b0;
    last     = (pos_q == len_q);
    case (state_q)
      P_IDLE: begin
        if (job_i.start) begin
          len_d    = job_i.len;
          cons_d   = job_i.consumed;
          status_d = job_i.status;
          pos_d    = '0;
          cnt_d    = '0;
          pend_d   = 1'b0;
          chunk_d  = '0;
          if ((job_i.status != STAT_OK) || (job_i.len == '0)) begin
            state_d = P_FIN;
          end else begin
            state_d = P_GATHER;
          end
        end
      end
      P_FIN: begin
        if (out_free) begin
          ov_d    = 1'b1;
          oc_d    = '0;
          ob_d    = '0;
          ol_d    = 1'b1;
          ocons_d = (status_q == STAT_OK) ? cons_q : '0;
          ost_d   = status_q;
          done_o  = 1'b1;
          state_d = P_IDLE;
        end
      end
      P_GATHER: begin
        if (pend_q) begin
          chunk_d[{cnt_q[2:0], 3'b000} +: BYTE_W] = nrdata_q;
          cnt_n = cnt_q + CNT_W'(1);
        end
        issue = (pos_q < len_q) && (cnt_n < CPR);
        cnt_d = cnt_n;
        if (issue) begin
          pos_d  = pos_q + LEN_W'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (out_free) begin
            ov_d    = 1'b1;
            oc_d    = chunk_d;
            ob_d    = cnt_n;
            ol_d    = last;
            ocons_d = last ? cons_q : '0;
            ost_d   = STAT_OK;
            chunk_d = '0;
            cnt_d   = '0;
            if (last) begin
              done_o  = 1'b1;
              state_d = P_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = P_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/dns_name_decompressor_core.sv]
// Top level: DNS name decompressor with message store and chunked name output.
// Load: one byte per cycle when idle; the block takes the next item in the following cycle.
// Decode: a label length byte or the closing zero takes W_FETCH and W_BYTE, a pointer also W_PTR,
// each label character W_LABEL; the packer reads the name buffer by character into chunks; the
// single store and name buffer read ports set these steps; results wait in an output register.
// Reset clears the sequencers and sets max_pointer_hops to 8; store contents are kept.
`timescale 1ns / 1ps

module dns_name_decompressor_core
  import dnsd_pkg::*;
#(
  parameter int STORE_BYTES      = STORE_BYTES_DEF,
  parameter int MAX_NAME_CHARS   = MAX_NAME_CHARS_DEF,
  parameter int CHARS_PER_RESULT = CHARS_PER_RESULT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               in_operation_i,
  input  logic [POS_W-1:0]   in_position_i,
  input  logic [BYTE_W-1:0]  in_byte_value_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [HOPS_W-1:0]  cfg_max_pointer_hops_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CHUNK_W-1:0] out_name_chunk_o,
  output logic [CNT_W-1:0]   out_chunk_bytes_o,
  output logic               out_last_chunk_o,
  output logic [CONS_W-1:0]  out_consumed_bytes_o,
  output logic [1:0]         out_status_o
);

  name_wr_t name_wr;
  job_t     job;
  logic     pack_done;

  dnsd_walker #(
    .STORE_BYTES   (STORE_BYTES),
    .MAX_NAME_CHARS(MAX_NAME_CHARS)
  ) u_walker (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .in_operation_i        (in_operation_i),
    .in_position_i         (in_position_i),
    .in_byte_value_i       (in_byte_value_i),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_max_pointer_hops_i(cfg_max_pointer_hops_i),
    .name_wr_o             (name_wr),
    .job_o                 (job),
    .pack_done_i           (pack_done)
  );

  dnsd_packer #(
    .MAX_NAME_CHARS  (MAX_NAME_CHARS),
    .CHARS_PER_RESULT(CHARS_PER_RESULT)
  ) u_packer (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .name_wr_i           (name_wr),
    .job_i               (job),
    .done_o              (pack_done),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_name_chunk_o    (out_name_chunk_o),
    .out_chunk_bytes_o   (out_chunk_bytes_o),
    .out_last_chunk_o    (out_last_chunk_o),
    .out_consumed_bytes_o(out_consumed_bytes_o),
    .out_status_o        (out_status_o)
  );

endmodule
